@@ rtl/midi_track_event_parser_defines.svh @@
// assertion macros for the midi track event parser
`ifndef MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MTEP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MTEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MTEP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MTEP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/mtep_pkg.sv @@
// types and constants shared by the midi track event parser
package mtep_pkg;

  localparam int QDepth = 2;
  localparam int QAw = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCw = $clog2(QDepth + 1);

  localparam logic [7:0] MetaEnd = 8'h2F;
  localparam logic [7:0] MetaTempo = 8'h51;
  localparam logic [3:0] HnProgram = 4'hC;
  localparam logic [3:0] HnChanPress = 4'hD;

  typedef enum logic [3:0] {
    PH_DELTA      = 4'd0,
    PH_STATUS     = 4'd1,
    PH_DATA1      = 4'd2,
    PH_DATA2      = 4'd3,
    PH_META_TYPE  = 4'd4,
    PH_META_LEN   = 4'd5,
    PH_META_DATA  = 4'd6,
    PH_SYSEX_LEN  = 4'd7,
    PH_SYSEX_DATA = 4'd8,
    PH_ENDED      = 4'd9
  } phase_t;

  typedef enum logic [3:0] {
    EV_NOTEOFF    = 4'd0,
    EV_NOTEON     = 4'd1,
    EV_POLYPRESS  = 4'd2,
    EV_CONTROLLER = 4'd3,
    EV_PROGRAM    = 4'd4,
    EV_CHANPRESS  = 4'd5,
    EV_PITCHBEND  = 4'd6,
    EV_TEMPO      = 4'd7,
    EV_ENDTRACK   = 4'd8,
    EV_OTHERMETA  = 4'd9,
    EV_SYSEX      = 4'd10,
    EV_ERROR      = 4'd11
  } kind_t;

  typedef enum logic [2:0] {
    CLS_DATA  = 3'd0,
    CLS_CHAN  = 3'd1,
    CLS_META  = 3'd2,
    CLS_SYSEX = 3'd3,
    CLS_BAD   = 3'd4
  } cls_t;

  typedef struct packed {
    logic [7:0] data;
    logic       track_start;
    cls_t       cls;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    kind_t        event_kind;
    logic [3:0]   channel;
    logic [6:0]   first_value;
    logic [6:0]   second_value;
    logic [31:0]  delta_ticks;
    logic [31:0]  tick_position;
    logic [23:0]  tempo_micros;
    logic [6:0]   meta_type;
  } res_t;

endpackage

@@ rtl/mtep_front.sv @@
// input stage: takes bytes, classifies them and pushes them into the queue
module mtep_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_track_start,
  input  mtep_pkg::q_stat_t   q_stat,
  output logic                push,
  output mtep_pkg::item_t     push_item
);

  logic            valid_r;
  logic            valid_nxt;
  mtep_pkg::item_t item_r;
  mtep_pkg::item_t item_nxt;
  mtep_pkg::cls_t  cls;

  always_comb begin
    if (!in_data_byte[7]) begin
      cls = mtep_pkg::CLS_DATA;
    end else if (in_data_byte < 8'hF0) begin
      cls = mtep_pkg::CLS_CHAN;
    end else if (in_data_byte == 8'hFF) begin
      cls = mtep_pkg::CLS_META;
    end else if (in_data_byte == 8'hF0 || in_data_byte == 8'hF7) begin
      cls = mtep_pkg::CLS_SYSEX;
    end else begin
      cls = mtep_pkg::CLS_BAD;
    end
  end

  assign push      = valid_r && !q_stat.full;
  assign in_ready  = !valid_r || !q_stat.full;
  assign push_item = item_r;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_valid && in_ready) begin
      valid_nxt            = 1'b1;
      item_nxt.data        = in_data_byte;
      item_nxt.track_start = in_track_start;
      item_nxt.cls         = cls;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

@@ rtl/mtep_queue.sv @@
// short fifo of classified bytes between the front and back parts
module mtep_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mtep_pkg::item_t   push_item,
  input  logic              pop,
  output mtep_pkg::item_t   head,
  output mtep_pkg::q_stat_t q_stat
);

  mtep_pkg::item_t             mem_r [mtep_pkg::QDepth];
  logic [mtep_pkg::QAw-1:0]    wr_ptr_r;
  logic [mtep_pkg::QAw-1:0]    wr_ptr_nxt;
  logic [mtep_pkg::QAw-1:0]    rd_ptr_r;
  logic [mtep_pkg::QAw-1:0]    rd_ptr_nxt;
  logic [mtep_pkg::QCw-1:0]    count_r;
  logic [mtep_pkg::QCw-1:0]    count_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == mtep_pkg::QCw'(mtep_pkg::QDepth));
  assign q_stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == mtep_pkg::QAw'(mtep_pkg::QDepth - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == mtep_pkg::QAw'(mtep_pkg::QDepth - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/mtep_back.sv @@
// parser state machine and result register
module mtep_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mtep_pkg::item_t   head,
  input  mtep_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output mtep_pkg::res_t    out_res
);

  mtep_pkg::phase_t phase_r, phase_nxt, ph;
  logic [7:0]  rs_r, rs_nxt, rs;
  logic [31:0] la_r, la_nxt, la;
  logic [31:0] hd_r, hd_nxt, hd;
  logic [6:0]  hf_r, hf_nxt, hf;
  logic [31:0] sk_r, sk_nxt, sk;
  logic [23:0] tp_r, tp_nxt, tp;
  logic [31:0] tk_r, tk_nxt, tk;
  logic [7:0]  mt_r, mt_nxt, mt;
  logic        res_valid_r, res_valid_nxt;
  mtep_pkg::res_t res_r, res_nxt;
  logic        emit;
  logic [31:0] vl;
  logic [32:0] tick_sum;
  logic [31:0] sk_dec;
  logic        one_data;
  logic [6:0]  second;
  logic [6:0]  d7;

  assign pop       = !q_stat.empty && (!res_valid_r || out_ready);
  assign out_valid = res_valid_r;
  assign out_res   = res_r;

  always_comb begin
    ph = head.track_start ? mtep_pkg::PH_DELTA : phase_r;
    rs = head.track_start ? 8'h00 : rs_r;
    la = head.track_start ? 32'h0 : la_r;
    hd = head.track_start ? 32'h0 : hd_r;
    hf = head.track_start ? 7'h00 : hf_r;
    sk = head.track_start ? 32'h0 : sk_r;
    tp = head.track_start ? 24'h0 : tp_r;
    tk = head.track_start ? 32'h0 : tk_r;
    mt = head.track_start ? 8'h00 : mt_r;
  end

  always_comb begin
    d7       = head.data[6:0];
    vl       = {la[24:0], d7};
    tick_sum = {1'b0, tk} + {1'b0, vl};
    sk_dec   = sk - 32'd1;
    one_data = (rs[7:4] == mtep_pkg::HnProgram) || (rs[7:4] == mtep_pkg::HnChanPress);
  end

  // next state
  always_comb begin
    phase_nxt = ph;
    rs_nxt    = rs;
    la_nxt    = la;
    hd_nxt    = hd;
    hf_nxt    = hf;
    sk_nxt    = sk;
    tp_nxt    = tp;
    tk_nxt    = tk;
    mt_nxt    = mt;
    case (ph)
      mtep_pkg::PH_STATUS: begin
        case (head.cls)
          mtep_pkg::CLS_DATA: begin
            if (rs == 8'h00) begin
              phase_nxt = mtep_pkg::PH_DELTA;
            end else begin
              hf_nxt    = d7;
              phase_nxt = one_data ? mtep_pkg::PH_DELTA : mtep_pkg::PH_DATA2;
            end
          end
          mtep_pkg::CLS_CHAN: begin
            rs_nxt    = head.data;
            phase_nxt = mtep_pkg::PH_DATA1;
          end
          mtep_pkg::CLS_META: begin
            rs_nxt    = 8'h00;
            phase_nxt = mtep_pkg::PH_META_TYPE;
          end
          mtep_pkg::CLS_SYSEX: begin
            rs_nxt    = 8'h00;
            la_nxt    = 32'h0;
            phase_nxt = mtep_pkg::PH_SYSEX_LEN;
          end
          default: begin
            rs_nxt    = 8'h00;
            phase_nxt = mtep_pkg::PH_DELTA;
          end
        endcase
      end
      mtep_pkg::PH_DATA1: begin
        hf_nxt    = d7;
        phase_nxt = one_data ? mtep_pkg::PH_DELTA : mtep_pkg::PH_DATA2;
      end
      mtep_pkg::PH_DATA2: begin
        phase_nxt = mtep_pkg::PH_DELTA;
      end
      mtep_pkg::PH_META_TYPE: begin
        mt_nxt    = head.data;
        la_nxt    = 32'h0;
        tp_nxt    = 24'h0;
        phase_nxt = mtep_pkg::PH_META_LEN;
      end
      mtep_pkg::PH_META_LEN: begin
        la_nxt = vl;
        if (!head.data[7]) begin
          sk_nxt = vl;
          la_nxt = 32'h0;
          if (vl == 32'h0) begin
            phase_nxt = (mt == mtep_pkg::MetaEnd) ? mtep_pkg::PH_ENDED : mtep_pkg::PH_DELTA;
          end else begin
            phase_nxt = mtep_pkg::PH_META_DATA;
          end
        end
      end
      mtep_pkg::PH_META_DATA: begin
        if (la < 32'd3) begin
          la_nxt = la + 32'd1;
          if (mt == mtep_pkg::MetaTempo) begin
            tp_nxt = {tp[15:0], head.data};
          end
        end
        sk_nxt = sk_dec;
        if (sk_dec == 32'h0) begin
          phase_nxt = (mt == mtep_pkg::MetaEnd) ? mtep_pkg::PH_ENDED : mtep_pkg::PH_DELTA;
        end
      end
      mtep_pkg::PH_SYSEX_LEN: begin
        la_nxt = vl;
        if (!head.data[7]) begin
          sk_nxt = vl;
          la_nxt = 32'h0;
          phase_nxt = (vl == 32'h0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SYSEX_DATA;
        end
      end
      mtep_pkg::PH_SYSEX_DATA: begin
        sk_nxt = sk_dec;
        if (sk_dec == 32'h0) begin
          phase_nxt = mtep_pkg::PH_DELTA;
        end
      end
      mtep_pkg::PH_ENDED: begin
        phase_nxt = mtep_pkg::PH_ENDED;
      end
      default: begin
        la_nxt    = vl;
        phase_nxt = mtep_pkg::PH_DELTA;
        if (!head.data[7]) begin
          hd_nxt    = vl;
          la_nxt    = 32'h0;
          tk_nxt    = tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0];
          phase_nxt = mtep_pkg::PH_STATUS;
        end
      end
    endcase
  end

  // result
  always_comb begin
    emit                  = 1'b0;
    second                = 7'h00;
    res_nxt.event_kind    = mtep_pkg::EV_ERROR;
    res_nxt.channel       = 4'h0;
    res_nxt.first_value   = 7'h00;
    res_nxt.second_value  = 7'h00;
    res_nxt.delta_ticks   = hd;
    res_nxt.tick_position = tk;
    res_nxt.tempo_micros  = 24'h0;
    res_nxt.meta_type     = 7'h00;
    case (ph)
      mtep_pkg::PH_STATUS: begin
        case (head.cls)
          mtep_pkg::CLS_DATA: begin
            emit = (rs == 8'h00) || one_data;
          end
          mtep_pkg::CLS_BAD: begin
            emit = 1'b1;
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
      mtep_pkg::PH_DATA1: begin
        emit = one_data;
      end
      mtep_pkg::PH_DATA2: begin
        emit   = 1'b1;
        second = d7;
      end
      mtep_pkg::PH_META_LEN: begin
        emit = !head.data[7] && (vl == 32'h0);
      end
      mtep_pkg::PH_META_DATA: begin
        emit = (sk_dec == 32'h0);
      end
      mtep_pkg::PH_SYSEX_LEN: begin
        emit = !head.data[7] && (vl == 32'h0);
      end
      mtep_pkg::PH_SYSEX_DATA: begin
        emit = (sk_dec == 32'h0);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    if (rs != 8'h00 &&
        ((ph == mtep_pkg::PH_STATUS && head.cls == mtep_pkg::CLS_DATA) ||
         ph == mtep_pkg::PH_DATA1 || ph == mtep_pkg::PH_DATA2)) begin
      res_nxt.event_kind   = mtep_pkg::kind_t'({1'b0, rs[6:4]});
      if (res_nxt.event_kind == mtep_pkg::EV_NOTEON && second == 7'h00) begin
        res_nxt.event_kind = mtep_pkg::EV_NOTEOFF;
      end
      res_nxt.channel      = rs[3:0];
      res_nxt.first_value  = hf_nxt;
      res_nxt.second_value = second;
    end else if (ph == mtep_pkg::PH_META_LEN || ph == mtep_pkg::PH_META_DATA) begin
      res_nxt.meta_type = mt[6:0];
      if (mt == mtep_pkg::MetaEnd) begin
        res_nxt.event_kind = mtep_pkg::EV_ENDTRACK;
      end else if (mt == mtep_pkg::MetaTempo) begin
        res_nxt.event_kind   = mtep_pkg::EV_TEMPO;
        res_nxt.tempo_micros = tp_nxt;
      end else begin
        res_nxt.event_kind = mtep_pkg::EV_OTHERMETA;
      end
    end else if (ph == mtep_pkg::PH_SYSEX_LEN || ph == mtep_pkg::PH_SYSEX_DATA) begin
      res_nxt.event_kind = mtep_pkg::EV_SYSEX;
    end
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (pop) begin
      res_valid_nxt = emit;
    end else if (out_ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= mtep_pkg::PH_DELTA;
      rs_r        <= 8'h00;
      la_r        <= 32'h0;
      hd_r        <= 32'h0;
      hf_r        <= 7'h00;
      sk_r        <= 32'h0;
      tp_r        <= 24'h0;
      tk_r        <= 32'h0;
      mt_r        <= 8'h00;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (pop) begin
        phase_r <= phase_nxt;
        rs_r    <= rs_nxt;
        la_r    <= la_nxt;
        hd_r    <= hd_nxt;
        hf_r    <= hf_nxt;
        sk_r    <= sk_nxt;
        tp_r    <= tp_nxt;
        tk_r    <= tk_nxt;
        mt_r    <= mt_nxt;
      end
    end
    if (pop && emit) begin
      res_r <= res_nxt;
    end
  end

endmodule

@@ rtl/midi_track_event_parser.sv @@
// midi track event parser top level
// a completing byte passes the input register, the queue, then the result register
// throughput: one byte per cycle unless the output stalls, set by the parser update
// a 2-entry queue between the classify stage and the parser absorbs output stalls
// reset: synchronous active-low rst_n empties the pipeline and returns the parser to
// expecting a delta time with no running status and zero tick position
`include "midi_track_event_parser_defines.svh"

module midi_track_event_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_track_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_event_kind,
  output logic [3:0]  out_channel,
  output logic [6:0]  out_first_value,
  output logic [6:0]  out_second_value,
  output logic [31:0] out_delta_ticks,
  output logic [31:0] out_tick_position,
  output logic [23:0] out_tempo_micros,
  output logic [6:0]  out_meta_type
);

  mtep_pkg::q_stat_t q_stat;
  mtep_pkg::item_t   push_item;
  mtep_pkg::item_t   head;
  mtep_pkg::res_t    res;
  logic              push;
  logic              pop;

  mtep_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_track_start (in_track_start),
    .q_stat         (q_stat),
    .push           (push),
    .push_item      (push_item)
  );

  mtep_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  mtep_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_event_kind    = res.event_kind;
  assign out_channel       = res.channel;
  assign out_first_value   = res.first_value;
  assign out_second_value  = res.second_value;
  assign out_delta_ticks   = res.delta_ticks;
  assign out_tick_position = res.tick_position;
  assign out_tempo_micros  = res.tempo_micros;
  assign out_meta_type     = res.meta_type;

  `MTEP_ASSERT_SAME(a_no_push_when_full, clk, rst_n, push, !q_stat.full)
  `MTEP_ASSERT_SAME(a_no_pop_when_empty, clk, rst_n, pop, !q_stat.empty)
  `MTEP_ASSERT_SAME(a_tempo_only_on_tempo, clk, rst_n,
    out_valid && (out_event_kind != mtep_pkg::EV_TEMPO), out_tempo_micros == 24'h0)
  `MTEP_ASSERT_NEXT(a_full_blocks_input, clk, rst_n,
    q_stat.full && !pop, !q_stat.empty)

endmodule
